// File: design/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, cell layout, character codes, sequencer states and the
// result record shared by the console modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Port widths of the item and result fields.
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int CELL_COL_W = 7;
  localparam int CELL_ROW_W = 5;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ACCESS,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attribute;
    logic [CELL_COL_W-1:0] cursor_column;
    logic [CELL_ROW_W-1:0] cursor_row;
    logic                  scrolled;
  } tcw_result_t;

endpackage

// File: design/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console sequencer
// Runs each item through the cell store: cursor stepping, one cell access,
// the scroll copy and bottom-row fill, and the reset clearing pass.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ATTR_W-1:0]     attr,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  opcode,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic                  use_position,
  input  logic [CELL_COL_W-1:0] cell_column,
  input  logic [CELL_ROW_W-1:0] cell_row,
  output tcw_result_t           result,
  output logic                  result_valid,
  input  logic                  result_stall
);

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELL_COUNT - COLUMNS);

  tcw_state_t state, state_next;

  logic [ADDR_W-1:0] cnt;
  logic              copy_valid;
  logic [ADDR_W-1:0] copy_addr;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic              result_valid_next;

  // Latched item, target cell already saturated.
  logic              item_read;
  logic [CHAR_W-1:0] item_char;
  logic [COL_W-1:0]  tgt_col;
  logic [ROW_W-1:0]  tgt_row;

  logic [ADDR_W-1:0] acc_addr;
  logic [CELL_W-1:0] acc_wdata;
  logic              acc_we;
  logic              scroll_flag;

  logic [COL_W-1:0]  sat_col;
  logic [ROW_W-1:0]  sat_row;

  logic              is_bs;
  logic              is_nl;
  logic              at_origin;
  logic              at_last_col;
  logic              at_last_row;
  logic              wrap;
  logic [ADDR_W-1:0] lin_addr;
  logic [ADDR_W-1:0] exec_addr;
  logic              exec_we;
  logic [CELL_W-1:0] exec_wdata;
  logic              exec_scroll;
  logic [COL_W-1:0]  exec_col;
  logic [ROW_W-1:0]  exec_row;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;
  logic              load_result;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Target cell of a new item: the given position, clamped, or the cursor.
  always_comb begin
    if (use_position) begin
      sat_col = (32'(cell_column) >= 32'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                   : COL_W'(cell_column);
      sat_row = (32'(cell_row) >= 32'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(cell_row);
    end else begin
      sat_col = cur_col;
      sat_row = cur_row;
    end
  end

  // Cursor stepping and cell address for the latched item.
  always_comb begin
    is_bs       = !item_read && (item_char == CH_BACKSPACE);
    is_nl       = !item_read && (item_char == CH_NEWLINE);
    at_origin   = (tgt_col == '0) && (tgt_row == '0);
    at_last_col = (tgt_col == COL_W'(COLUMNS - 1));
    at_last_row = (tgt_row == ROW_W'(ROWS - 1));
    wrap        = !item_read && !is_bs && (is_nl || at_last_col);
    exec_scroll = wrap && at_last_row;
    lin_addr    = ADDR_W'(tgt_row) * ROW_STRIDE + ADDR_W'(tgt_col);
    // Backspace blanks the cell one place before the target.
    exec_addr   = is_bs ? lin_addr - ADDR_W'(1) : lin_addr;
    exec_we     = !item_read && !is_nl && !(is_bs && at_origin);
    exec_wdata  = {attr, (is_bs ? CH_SPACE : item_char)};
    exec_col    = cur_col;
    exec_row    = cur_row;
    if (item_read) begin
      exec_col = cur_col;
      exec_row = cur_row;
    end else if (is_bs) begin
      if (!at_origin) begin
        if (tgt_col == '0) begin
          exec_col = COL_W'(COLUMNS - 1);
          exec_row = tgt_row - ROW_W'(1);
        end else begin
          exec_col = tgt_col - COL_W'(1);
          exec_row = tgt_row;
        end
      end
    end else if (wrap) begin
      exec_col = '0;
      exec_row = at_last_row ? tgt_row : tgt_row + ROW_W'(1);
    end else begin
      exec_col = tgt_col + COL_W'(1);
      exec_row = tgt_row;
    end
  end

  // Next state.
  always_comb begin
    case (state)
      ST_CLEAR:  state_next = (cnt == LAST_ADDR) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_next = item_valid ? ST_EXEC : ST_IDLE;
      ST_EXEC:   state_next = ST_ACCESS;
      ST_ACCESS: state_next = scroll_flag ? ST_SCROLL : ST_DONE;
      ST_SCROLL: state_next = (cnt == LAST_ADDR) ? ST_FILL : ST_SCROLL;
      ST_FILL:   state_next = (!copy_valid && cnt == LAST_ADDR) ? ST_DONE : ST_FILL;
      ST_DONE:   state_next = load_result ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs: store port control, input stall and result load.
  always_comb begin
    item_stall  = (state != ST_IDLE);
    load_result = (state == ST_DONE) && (!result_valid || !result_stall);
    mem_we      = 1'b0;
    mem_waddr   = cnt;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cnt;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_ACCESS: begin
        mem_we    = acc_we;
        mem_waddr = acc_addr;
        mem_wdata = acc_wdata;
        mem_re    = item_read;
        mem_raddr = acc_addr;
      end
      ST_SCROLL: begin
        // Read one row below, write the cell read in the previous cycle.
        mem_re    = 1'b1;
        mem_we    = copy_valid;
        mem_waddr = copy_addr;
        mem_wdata = mem_rdata;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (copy_valid) begin
          mem_waddr = copy_addr;
          mem_wdata = mem_rdata;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    if (load_result) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cnt          <= '0;
      copy_valid   <= 1'b0;
      cur_col      <= '0;
      cur_row      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + ADDR_W'(1);
        end
        ST_EXEC: begin
          cur_col <= exec_col;
          cur_row <= exec_row;
        end
        ST_ACCESS: begin
          cnt        <= ROW_STRIDE;
          copy_valid <= 1'b0;
        end
        ST_SCROLL: begin
          copy_valid <= 1'b1;
          cnt        <= (cnt == LAST_ADDR) ? LAST_ROW_BASE : cnt + ADDR_W'(1);
        end
        ST_FILL: begin
          if (copy_valid) begin
            copy_valid <= 1'b0;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_read <= (opcode == OP_READ);
          item_char <= char_code;
          tgt_col   <= sat_col;
          tgt_row   <= sat_row;
        end
      end
      ST_EXEC: begin
        acc_addr    <= exec_addr;
        acc_wdata   <= exec_wdata;
        acc_we      <= exec_we;
        scroll_flag <= exec_scroll;
      end
      ST_SCROLL: begin
        copy_addr <= cnt - ROW_STRIDE;
      end
      ST_DONE: begin
        if (load_result) begin
          result.cell_char      <= item_read ? mem_rdata[CHAR_W-1:0] : '0;
          result.cell_attribute <= item_read ? mem_rdata[CELL_W-1:CHAR_W] : '0;
          result.cursor_column  <= CELL_COL_W'(cur_col);
          result.cursor_row     <= CELL_ROW_W'(cur_row);
          result.scrolled       <= scroll_flag;
        end
      end
      default: begin
        item_read <= item_read;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_copy_in_scroll: assert property (@(posedge clk) disable iff (rst)
    copy_valid |-> (state == ST_SCROLL || state == ST_FILL))
    else $error("scroll copy pending outside the scroll sequence");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < CELL_COUNT))
    else $error("cell store write beyond the screen");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLUMNS) && (32'(cur_row) < ROWS))
    else $error("cursor left the screen");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && scroll_flag) |-> (cur_row == ROW_W'(ROWS - 1)))
    else $error("scroll did not leave the cursor on the bottom row");
`endif

endmodule

// File: design/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 character cell store with a linear cursor, put and read items.
// ----------------------------------------------------------------------------
// Items arrive on the item channel (item_valid / item_stall); each one gives
// exactly one beat on the result channel (result_valid / result_stall).
// A put writes char_code with the attribute register at the cursor or at the
// given cell and advances the cursor; newline and backspace move it instead.
// A read returns the cell contents; puts return zero cell data.
// The attribute register is to be written over config_valid / config_ready
// only while the block is idle; the block itself does not enforce this, and
// config_ready is always high. Each item passes through the states in order:
// latch and clamp the target, step the cursor and form the address, one
// access on the cell store, load the result register; item_stall stays high
// until the result is loaded, so the next item waits for the last one.
// An item that scrolls also copies 1920 cells up one row, one cell per
// cycle, then writes the last copy and fills the 80 cells of the bottom row.
// After reset the store is cleared, one cell per cycle, all 2000 cells, with
// item_stall high. A stalled result holds in the output register; the next
// item is accepted meanwhile but finishes only once that beat is taken.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  config_valid,
  output logic                  config_ready,
  input  logic [ATTR_W-1:0]     config_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  opcode,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic                  use_position,
  input  logic [CELL_COL_W-1:0] cell_column,
  input  logic [CELL_ROW_W-1:0] cell_row,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [CHAR_W-1:0]     cell_char,
  output logic [ATTR_W-1:0]     cell_attribute,
  output logic [CELL_COL_W-1:0] cursor_column,
  output logic [CELL_ROW_W-1:0] cursor_row,
  output logic                  scrolled
);

  logic [ATTR_W-1:0] text_attribute;
  tcw_result_t       result;

  assign config_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (config_valid && config_ready) begin
      text_attribute <= config_data;
    end
  end

  tcw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .attr        (text_attribute),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .opcode      (opcode),
    .char_code   (char_code),
    .use_position(use_position),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

  assign cell_char      = result.cell_char;
  assign cell_attribute = result.cell_attribute;
  assign cursor_column  = result.cursor_column;
  assign cursor_row     = result.cursor_row;
  assign scrolled       = result.scrolled;

endmodule
